/* hw/rtl/lca_pkg.sv */
// ----------------------------------------------------------------------------
// lca_pkg
// types, constants and control structs of the leader clustering block
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int MAX_CENTERS  = 64;
  localparam int DIMS         = 4;
  localparam int COORD_BITS   = 16;
  localparam int IDX_BITS     = $clog2(MAX_CENTERS);
  localparam int CNT_BITS     = $clog2(MAX_CENTERS + 1);
  localparam int RADIUS_BITS  = 16;
  localparam int LIMIT_BITS   = 2 * RADIUS_BITS;
  localparam int SQ_BITS      = 2 * COORD_BITS;
  localparam int SUM_BITS     = SQ_BITS + $clog2(DIMS) + 1;
  localparam int WORD_BITS    = DIMS * COORD_BITS;
  localparam int RADIUS_RESET = 256;

  typedef logic [DIMS-1:0][COORD_BITS-1:0] point_t;

  typedef struct packed {
    logic                          restart;
    logic signed [COORD_BITS-1:0]  coord_0;
    logic signed [COORD_BITS-1:0]  coord_1;
    logic signed [COORD_BITS-1:0]  coord_2;
    logic signed [COORD_BITS-1:0]  coord_3;
  } in_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] cluster_index;
    logic                new_cluster;
    logic                overflow;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic resolve_hit;
    logic resolve_miss;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic busy;
    logic hit;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/lca_ram.sv */
// ----------------------------------------------------------------------------
// lca_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/lca_datapath.sv */
// ----------------------------------------------------------------------------
// lca_datapath
// center memory, distance pipeline, center count and output register
// ----------------------------------------------------------------------------
module lca_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lca_pkg::cmd_t                       cmd,
  output lca_pkg::status_t                    st,
  input  lca_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lca_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  input  logic [lca_pkg::RADIUS_BITS-1:0]     cfg_data
);

  lca_pkg::point_t                   point;
  logic [lca_pkg::CNT_BITS-1:0]      count;
  logic [lca_pkg::CNT_BITS-1:0]      k;
  logic                              s1_v;
  logic [lca_pkg::IDX_BITS-1:0]      s1_idx;
  logic                              s2_v;
  logic [lca_pkg::IDX_BITS-1:0]      s2_idx;
  logic [lca_pkg::SQ_BITS-1:0]       sq [lca_pkg::DIMS];
  logic [lca_pkg::LIMIT_BITS-1:0]    limit;
  lca_pkg::out_t                     pend;
  logic [lca_pkg::WORD_BITS-1:0]     rd_word;
  lca_pkg::point_t                   center;
  logic [lca_pkg::SUM_BITS-1:0]      sum;
  logic                              full;
  logic                              hit;
  logic                              wr_en;

  lca_ram #(
    .WIDTH (lca_pkg::WORD_BITS),
    .DEPTH (lca_pkg::MAX_CENTERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[lca_pkg::IDX_BITS-1:0]),
    .wr_data (point),
    .rd_en   (cmd.issue),
    .rd_addr (k[lca_pkg::IDX_BITS-1:0]),
    .rd_data (rd_word)
  );

  assign center = rd_word;
  assign full   = (count == lca_pkg::CNT_BITS'(lca_pkg::MAX_CENTERS));
  assign wr_en  = cmd.resolve_miss && !full;

  always_comb begin
    sum = '0;
    for (int d = 0; d < lca_pkg::DIMS; d++) begin
      sum = sum + lca_pkg::SUM_BITS'(sq[d]);
    end
  end

  assign hit = s2_v && (sum < lca_pkg::SUM_BITS'(limit));

  assign st.more     = (k < count);
  assign st.busy     = s1_v || s2_v;
  assign st.hit      = hit;
  assign st.out_free = !out_valid || out_ready;

  // radius squared, taken on the config transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= lca_pkg::LIMIT_BITS'(lca_pkg::RADIUS_RESET * lca_pkg::RADIUS_RESET);
    end else if (cfg_valid) begin
      limit <= lca_pkg::LIMIT_BITS'(cfg_data) * lca_pkg::LIMIT_BITS'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      point <= {in_data.coord_3, in_data.coord_2, in_data.coord_1, in_data.coord_0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept && in_data.restart) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.accept) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= k + 1'b1;
    end
  end

  // read, square, compare pipeline
  always_ff @(posedge clk) begin
    if (rst || cmd.accept || cmd.resolve_hit) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= k[lca_pkg::IDX_BITS-1:0];
    s2_idx <= s1_idx;
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < lca_pkg::DIMS; d++) begin
      logic signed [lca_pkg::COORD_BITS:0] diff;
      logic [lca_pkg::COORD_BITS-1:0]      mag;
      diff = $signed({point[d][lca_pkg::COORD_BITS-1], point[d]})
           - $signed({center[d][lca_pkg::COORD_BITS-1], center[d]});
      mag  = diff[lca_pkg::COORD_BITS] ? lca_pkg::COORD_BITS'(-diff)
                                       : lca_pkg::COORD_BITS'(diff);
      sq[d] <= lca_pkg::SQ_BITS'(mag) * lca_pkg::SQ_BITS'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve_hit) begin
      pend.cluster_index <= s2_idx;
      pend.new_cluster   <= 1'b0;
      pend.overflow      <= 1'b0;
    end else if (cmd.resolve_miss) begin
      pend.cluster_index <= full ? '0 : count[lca_pkg::IDX_BITS-1:0];
      pend.new_cluster   <= !full;
      pend.overflow      <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= pend;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lca_pkg::CNT_BITS'(lca_pkg::MAX_CENTERS))
    else $error("center count above table size");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("result overwrites a pending transaction");

  a_idx_stored: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> ({1'b0, s2_idx} < count))
    else $error("compared center was never stored");
`endif

endmodule

/* hw/rtl/lca_ctrl.sv */
// ----------------------------------------------------------------------------
// lca_ctrl
// scan controller: accept, issue center reads, resolve, hand off result
// ----------------------------------------------------------------------------
module lca_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lca_pkg::status_t st,
  output lca_pkg::cmd_t    cmd
);

  lca_pkg::state_t state;
  lca_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lca_pkg::ST_IDLE: begin
        if (in_valid) state_next = lca_pkg::ST_SCAN;
      end
      lca_pkg::ST_SCAN: begin
        if (st.hit || (!st.more && !st.busy)) state_next = lca_pkg::ST_FINISH;
      end
      lca_pkg::ST_FINISH: begin
        if (st.out_free) state_next = lca_pkg::ST_IDLE;
      end
      default: state_next = lca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      lca_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lca_pkg::ST_SCAN: begin
        if (st.hit) begin
          cmd.resolve_hit = 1'b1;
        end else if (!st.more && !st.busy) begin
          cmd.resolve_miss = 1'b1;
        end else begin
          cmd.issue = st.more;
        end
      end
      lca_pkg::ST_FINISH: begin
        cmd.emit = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_hit_finish: assert property (@(posedge clk) disable iff (rst)
    (state == lca_pkg::ST_SCAN && st.hit) |=> state == lca_pkg::ST_FINISH)
    else $error("match not resolved");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == lca_pkg::ST_IDLE)
    else $error("no return to idle after result");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.issue, cmd.resolve_hit, cmd.resolve_miss, cmd.emit}))
    else $error("conflicting datapath commands");
`endif

endmodule

/* hw/rtl/leader_clustering_assign_top.sv */
// ----------------------------------------------------------------------------
// leader_clustering_assign_top
// sequential leader clustering: assigns each point to the first stored center
// within the radius, or stores it as a new center
// ----------------------------------------------------------------------------
// scan: stored centers are read in order and the point resolves at the first
//   match m, or as a miss once all n stored centers (n at most 64) are compared
// flow: a new point is accepted only after the last result is registered for
//   output; the single read port of the center memory compares one center per cycle
// reset: center count cleared, radius 256, memory contents not cleared
// ----------------------------------------------------------------------------
module leader_clustering_assign_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lca_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lca_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lca_pkg::RADIUS_BITS-1:0]  cfg_data
);

  lca_pkg::cmd_t    cmd;
  lca_pkg::status_t st;

  assign cfg_ready = 1'b1;

  lca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lca_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// testbench of leader_clustering_assign_top: a table of directed points
// (coordinate extremes, threshold edge, restart, zero radius, full table)
// followed by random point sets clustered around random seeds under many
// radius settings. Each accepted point is run through a local cluster
// table whose assignments are compared with the returned results. The
// sender runs in bursts, the receiver stalls on its own pattern and holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int N_RANDOM    = 1470;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    bit                              set_radius;
    logic [lca_pkg::RADIUS_BITS-1:0] radius;
    int                              reps;
    bit                              rs;
    logic [lca_pkg::COORD_BITS-1:0]  c0;
    logic [lca_pkg::COORD_BITS-1:0]  c1;
    logic [lca_pkg::COORD_BITS-1:0]  c2;
    logic [lca_pkg::COORD_BITS-1:0]  c3;
    bit                              typed;
    logic [lca_pkg::IDX_BITS-1:0]    idx;
    bit                              nw;
    bit                              ov;
  } dir_row_t;

  // set_radius radius reps restart coords typed idx new overflow
  dir_row_t dir_tab [17] = '{
    '{0, 16'd0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 6'd0, 1, 0},
    '{0, 16'd0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 6'd0, 0, 0},
    '{0, 16'd0, 1, 0, 16'h00FF, 16'h0000, 16'h0000, 16'h0000, 0, 6'd0, 0, 0},
    '{0, 16'd0, 1, 0, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 0, 6'd0, 0, 0},
    '{0, 16'd0, 1, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 6'd0, 0, 0},
    '{0, 16'd0, 1, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 6'd0, 0, 0},
    '{0, 16'd0, 1, 1, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 6'd0, 1, 0},
    '{1, 16'hFFFF, 1, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 6'd0, 1, 0},
    '{0, 16'd0, 1, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 6'd0, 0, 0},
    '{0, 16'd0, 1, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 6'd0, 0, 0},
    '{0, 16'd0, 1, 0, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 0, 6'd0, 0, 0},
    '{1, 16'h0000, 64, 1, 16'h0005, 16'h0005, 16'h0005, 16'h0005, 0, 6'd0, 0, 0},
    '{0, 16'd0, 1, 0, 16'h0005, 16'h0005, 16'h0005, 16'h0005, 1, 6'd0, 0, 1},
    '{0, 16'd0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 6'd0, 0, 1},
    '{1, 16'd1, 1, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 6'd0, 1, 0},
    '{0, 16'd0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 6'd0, 0, 0},
    '{0, 16'd0, 1, 0, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 0, 6'd0, 0, 0}
  };

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  lca_pkg::in_t                    in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  lca_pkg::out_t                   out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lca_pkg::RADIUS_BITS-1:0] cfg_data  = '0;

  logic signed [lca_pkg::COORD_BITS-1:0] center_tab [lca_pkg::MAX_CENTERS][lca_pkg::DIMS];
  int                              center_cnt = 0;
  logic [lca_pkg::RADIUS_BITS-1:0] radius_q   =
    lca_pkg::RADIUS_BITS'(lca_pkg::RADIUS_RESET);
  lca_pkg::out_t                   pending_assign_q [$];
  lca_pkg::out_t                   want;
  int                              err_cnt      = 0;
  int                              results_seen = 0;
  int                              burst_left   = 0;
  int                              rand_sent    = 0;

  always #4 clk = ~clk;

  leader_clustering_assign_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic lca_pkg::out_t assign_point(lca_pkg::in_t pt);
    logic signed [lca_pkg::COORD_BITS-1:0] p [lca_pkg::DIMS];
    longint unsigned lim;
    longint unsigned dsq;
    longint          diff;
    lca_pkg::out_t   res;
    bit              hit;
    p[0] = pt.coord_0;
    p[1] = pt.coord_1;
    p[2] = pt.coord_2;
    p[3] = pt.coord_3;
    if (pt.restart) center_cnt = 0;
    lim = 64'(radius_q) * 64'(radius_q);
    res = '0;
    hit = 1'b0;
    for (int k = 0; k < center_cnt && !hit; k++) begin
      dsq = 0;
      for (int d = 0; d < lca_pkg::DIMS; d++) begin
        diff = longint'(p[d]) - longint'(center_tab[k][d]);
        dsq += diff * diff;
      end
      if (dsq < lim) begin
        hit = 1'b1;
        res.cluster_index = lca_pkg::IDX_BITS'(k);
      end
    end
    if (!hit) begin
      if (center_cnt >= lca_pkg::MAX_CENTERS) begin
        res.overflow = 1'b1;
      end else begin
        for (int d = 0; d < lca_pkg::DIMS; d++) center_tab[center_cnt][d] = p[d];
        res.cluster_index = lca_pkg::IDX_BITS'(center_cnt);
        res.new_cluster   = 1'b1;
        center_cnt++;
      end
    end
    return res;
  endfunction

  function automatic logic [lca_pkg::COORD_BITS-1:0] jitter(int amp);
    return lca_pkg::COORD_BITS'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  function automatic logic [lca_pkg::COORD_BITS-1:0] corner_coord();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic send_point(lca_pkg::in_t pt, bit typed = 1'b0,
                            lca_pkg::out_t typed_res = '0);
    int idle;
    lca_pkg::out_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0) idle = 0;
      else if ($urandom_range(0, 4) == 0) idle = $urandom_range(1, 90);
      else idle = $urandom_range(1, 8);
      if (idle > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= pt;
    do @(posedge clk); while (!in_ready);
    res = assign_point(pt);
    if (typed) res = typed_res;
    pending_assign_q.insert(pending_assign_q.size(), res);
  endtask

  task automatic write_radius(logic [lca_pkg::RADIUS_BITS-1:0] r);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_assign_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    radius_q = r;
    @(negedge clk);
    cfg_valid  <= 1'b0;
    burst_left = 0;
  endtask

  task automatic run_point_set(int n_pts);
    lca_pkg::in_t seeds [16];
    lca_pkg::in_t s;
    lca_pkg::in_t pt;
    int  n_seeds;
    int  amp;
    int  m;
    n_seeds = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 8);
    for (int k = 0; k < n_seeds; k++) begin
      seeds[k].restart = 1'b0;
      seeds[k].coord_0 = lca_pkg::COORD_BITS'($urandom());
      seeds[k].coord_1 = lca_pkg::COORD_BITS'($urandom());
      seeds[k].coord_2 = lca_pkg::COORD_BITS'($urandom());
      seeds[k].coord_3 = lca_pkg::COORD_BITS'($urandom());
    end
    if (radius_q == 0) amp = 8;
    else if ($urandom_range(0, 1) == 1) amp = int'(radius_q);
    else amp = int'(radius_q) / 4 + 1;
    for (int k = 0; k < n_pts; k++) begin
      m  = $urandom_range(0, 9);
      s  = seeds[$urandom_range(0, n_seeds - 1)];
      pt.restart = (k == 0) || ($urandom_range(0, 59) == 0);
      if (m < 7) begin
        pt.coord_0 = s.coord_0 + jitter(amp);
        pt.coord_1 = s.coord_1 + jitter(amp);
        pt.coord_2 = s.coord_2 + jitter(amp);
        pt.coord_3 = s.coord_3 + jitter(amp);
      end else if (m < 9) begin
        pt.coord_0 = lca_pkg::COORD_BITS'($urandom());
        pt.coord_1 = lca_pkg::COORD_BITS'($urandom());
        pt.coord_2 = lca_pkg::COORD_BITS'($urandom());
        pt.coord_3 = lca_pkg::COORD_BITS'($urandom());
      end else begin
        pt.coord_0 = corner_coord();
        pt.coord_1 = corner_coord();
        pt.coord_2 = corner_coord();
        pt.coord_3 = corner_coord();
      end
      send_point(pt);
      rand_sent++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_assign_q.size() == 0) begin
        if (err_cnt < 10)
          $display("unexpected transaction: idx %0d new %0b ovf %0b",
                   out_data.cluster_index, out_data.new_cluster, out_data.overflow);
        err_cnt++;
      end else begin
        want = pending_assign_q.pop_front();
        if (out_data.cluster_index !== want.cluster_index ||
            out_data.new_cluster !== want.new_cluster ||
            out_data.overflow !== want.overflow) begin
          if (err_cnt < 10)
            $display("mismatch: expected idx %0d new %0b ovf %0b, got idx %0d new %0b ovf %0b",
                     want.cluster_index, want.new_cluster, want.overflow,
                     out_data.cluster_index, out_data.new_cluster, out_data.overflow);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int  mode;
    int  len;
    bit  held;
    held = 1'b0;
    forever begin
      if (!held && results_seen >= 300 && in_valid) begin
        held = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 60);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog
  initial begin
    int idle_cyc;
    idle_cyc = 0;
    while (idle_cyc < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle_cyc = 0;
      else
        idle_cyc++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    dir_row_t      row;
    lca_pkg::in_t  pt;
    lca_pkg::out_t typed_res;
    int            set_size;
    logic [lca_pkg::RADIUS_BITS-1:0] r;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(dir_tab); i++) begin
      row = dir_tab[i];
      if (row.set_radius) write_radius(row.radius);
      for (int k = 0; k < row.reps; k++) begin
        pt.restart = row.rs && (k == 0);
        pt.coord_0 = row.c0;
        pt.coord_1 = row.c1;
        pt.coord_2 = row.c2;
        pt.coord_3 = row.c3;
        typed_res.cluster_index = row.idx;
        typed_res.new_cluster   = row.nw;
        typed_res.overflow      = row.ov;
        send_point(pt, row.typed, typed_res);
      end
    end

    while (rand_sent < N_RANDOM) begin
      case ($urandom_range(0, 7))
        0: r = '0;
        1: r = '1;
        2: r = lca_pkg::RADIUS_BITS'(lca_pkg::RADIUS_RESET);
        3: r = lca_pkg::RADIUS_BITS'($urandom_range(1, 64));
        4, 5: r = lca_pkg::RADIUS_BITS'($urandom_range(256, 4096));
        6: r = lca_pkg::RADIUS_BITS'($urandom());
        default: r = lca_pkg::RADIUS_BITS'($urandom_range(8192, 40000));
      endcase
      write_radius(r);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0) set_size = $urandom_range(90, 140);
        else set_size = $urandom_range(4, 50);
        if (set_size > N_RANDOM - rand_sent) set_size = N_RANDOM - rand_sent;
        if (set_size > 0) run_point_set(set_size);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_assign_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_cnt == 0 && pending_assign_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
